// ----- design/wbwm_pkg.sv -----
package wbwm_pkg;

  localparam int unsigned WordMax   = 8;
  localparam int unsigned DictMax   = 16;
  localparam int unsigned WindowMax = 16;
  localparam int unsigned PhaseW    = $clog2(WordMax);
  localparam int unsigned IdW       = $clog2(DictMax);
  localparam int unsigned SlotW     = $clog2(WindowMax);
  localparam int unsigned CntW      = $clog2(WindowMax) + 1;
  localparam int unsigned DictCntW  = $clog2(DictMax) + 1;
  localparam int unsigned PosW      = 17;
  localparam int unsigned SeenAw    = PhaseW + IdW;
  localparam int unsigned WidAw     = PhaseW + SlotW;

  typedef enum logic [1:0] {
    OP_DICT  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LOOK,
    S_SRD,
    S_SCHK,
    S_CHK,
    S_PW,
    S_PS,
    S_PD,
    S_APP,
    S_EMIT
  } state_e;

endpackage

// ----- design/word_bag_window_matcher.sv -----
// Word bag window matcher. Dictionary symbols (op 0) build a table of up to 16 distinct
// words; text symbols (op 1) are matched against it and a result is given where a
// concatenation of the whole bag ends, or on the final text symbol. One transaction is
// taken at a time through a small sequencer: a dictionary symbol that completes a word
// also runs a table search; a text symbol that ends a word runs a bit-serial
// remainder for the phase, a table search, a check that drops words from the window
// as needed, an append, and then a load of the output register. The table search
// compares one stored word per cycle and the window bookkeeping uses memories with
// one write port and one registered read port.
module word_bag_window_matcher
  import wbwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  symbol_i,
  input  logic        final_symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] match_start_o,
  output logic        is_match_o,
  output logic        is_end_o,
  output logic        dict_overflow_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;
  logic [3:0] wl_q;
  logic [DictCntW-1:0] used_q, used_d;
  logic [CntW-1:0] total_q, total_d;
  logic ovf_q, ovf_d;
  logic [7:0] recent_q [WordMax];
  logic [2:0] fill_q, fill_d;
  logic [PosW-1:0] pos_q, pos_d, cpos_q, cpos_d, div_q, div_d;
  logic [SlotW-1:0] head_q [WordMax];
  logic [SlotW-1:0] head_d [WordMax];
  logic [CntW-1:0] size_q [WordMax];
  logic [CntW-1:0] size_d [WordMax];
  logic text_q, text_d, fin_q, fin_d, match_q, match_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic [3:0] rem_q, rem_d;
  logic [DictCntW-1:0] idx_q, idx_d;
  logic [IdW-1:0] id_q, id_d, old_q, old_d;
  logic [CntW-1:0] cur_q, cur_d;
  logic [15:0] start_q, start_d;

  logic [63:0] words_q [DictMax];
  logic [CntW-1:0] counts_q [DictMax];
  logic [CntW-1:0] seen_mem [2**SeenAw];
  logic [IdW-1:0] wid_mem [2**WidAw];
  logic [2**SeenAw-1:0] vld_q;
  logic [CntW-1:0] seen_rd_q;
  logic [IdW-1:0] wid_rd_q;

  logic out_valid_q;
  logic [15:0] out_start_q;
  logic out_match_q, out_end_q, out_ovf_q;

  logic in_acc, shift_en, dict_wr, cnt_inc, seen_we, wid_we, vld_clr_all, vld_clr_ph;
  logic out_load;
  logic [SeenAw-1:0] seen_raddr, seen_waddr;
  logic [CntW-1:0] seen_wdata;
  logic [WidAw-1:0] wid_raddr, wid_waddr;
  logic [3:0] len;
  logic [63:0] word;
  logic [PhaseW-1:0] ph;
  logic [3:0] fill_inc, rt;
  logic [CntW-1:0] sz, pval, pdec, nsz;
  logic [8:0] span;

  always_comb begin
    priority if (wl_q == 4'd0) len = 4'd1;
    else if (wl_q > 4'(WordMax)) len = 4'(WordMax);
    else len = wl_q;
  end

  always_comb begin
    for (int k = 0; k < WordMax; k++) begin
      word[8*k +: 8] = (4'(k) < len) ? recent_q[k] : 8'd0;
    end
  end

  assign ph = rem_q[PhaseW-1:0];
  assign sz = size_q[ph];
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign fill_inc = {1'b0, fill_q} + 4'd1;
  assign rt = {rem_q[2:0], div_q[PosW-1]};
  assign pval = vld_q[{ph, old_q}] ? seen_rd_q : '0;
  assign pdec = (pval != '0) ? pval - 1'b1 : '0;
  assign nsz = sz + 1'b1;
  assign span = 9'(nsz) * 9'(len);

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    total_d = total_q;
    ovf_d = ovf_q;
    fill_d = fill_q;
    pos_d = pos_q;
    cpos_d = cpos_q;
    div_d = div_q;
    head_d = head_q;
    size_d = size_q;
    text_d = text_q;
    fin_d = fin_q;
    match_d = match_q;
    dcnt_d = dcnt_q;
    rem_d = rem_q;
    idx_d = idx_q;
    id_d = id_q;
    old_d = old_q;
    cur_d = cur_q;
    start_d = start_q;
    shift_en = 1'b0;
    dict_wr = 1'b0;
    cnt_inc = 1'b0;
    seen_we = 1'b0;
    seen_waddr = {ph, id_q};
    seen_wdata = cur_q;
    seen_raddr = {ph, id_q};
    wid_we = 1'b0;
    wid_raddr = {ph, head_q[ph]};
    wid_waddr = {ph, SlotW'(head_q[ph] + sz[SlotW-1:0])};
    vld_clr_all = 1'b0;
    vld_clr_ph = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(op_i))
            OP_DICT: begin
              if (pos_q == '0) begin
                shift_en = 1'b1;
                if (fill_inc >= len) begin
                  fill_d = '0;
                  if (total_q >= CntW'(WindowMax)) begin
                    ovf_d = 1'b1;
                  end else begin
                    text_d = 1'b0;
                    idx_d = '0;
                    state_d = S_LOOK;
                  end
                end else begin
                  fill_d = fill_inc[2:0];
                end
              end
            end
            OP_TEXT: begin
              fill_d = '0;
              fin_d = final_symbol_i;
              match_d = 1'b0;
              state_d = final_symbol_i ? S_EMIT : S_IDLE;
              if (!pos_q[PosW-1]) begin
                shift_en = 1'b1;
                cpos_d = pos_q;
                pos_d = pos_q + 1'b1;
                if (pos_q + 1'b1 >= PosW'(len)) begin
                  div_d = pos_q + 1'b1;
                  dcnt_d = 5'(PosW);
                  rem_d = '0;
                  text_d = 1'b1;
                  state_d = S_DIV;
                end
              end
            end
            OP_CLEAR: begin
              used_d = '0;
              total_d = '0;
              ovf_d = 1'b0;
              fill_d = '0;
              pos_d = '0;
              vld_clr_all = 1'b1;
              for (int k = 0; k < WordMax; k++) begin
                head_d[k] = '0;
                size_d[k] = '0;
              end
            end
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_d = (rt >= len) ? rt - len : rt;
        div_d = div_q << 1;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd1) begin
          idx_d = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (idx_q == used_q) begin
          if (text_q) begin
            vld_clr_ph = 1'b1;
            head_d[ph] = '0;
            size_d[ph] = '0;
            state_d = fin_q ? S_EMIT : S_IDLE;
          end else begin
            if (used_q < DictCntW'(DictMax)) begin
              dict_wr = 1'b1;
              used_d = used_q + 1'b1;
              total_d = total_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            state_d = S_IDLE;
          end
        end else if (words_q[idx_q[IdW-1:0]] == word) begin
          id_d = idx_q[IdW-1:0];
          if (text_q) begin
            state_d = S_SRD;
          end else begin
            cnt_inc = 1'b1;
            total_d = total_q + 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SRD: state_d = S_SCHK;
      S_SCHK: begin
        cur_d = vld_q[{ph, id_q}] ? seen_rd_q : '0;
        state_d = S_CHK;
      end
      S_CHK: begin
        if ((sz != '0 && cur_q >= counts_q[id_q]) || sz >= CntW'(WindowMax)) begin
          state_d = S_PW;
        end else begin
          state_d = S_APP;
        end
      end
      S_PW: state_d = S_PS;
      S_PS: begin
        old_d = wid_rd_q;
        seen_raddr = {ph, wid_rd_q};
        state_d = S_PD;
      end
      S_PD: begin
        seen_we = 1'b1;
        seen_waddr = {ph, old_q};
        seen_wdata = pdec;
        if (old_q == id_q) cur_d = pdec;
        head_d[ph] = head_q[ph] + 1'b1;
        size_d[ph] = sz - 1'b1;
        state_d = S_CHK;
      end
      S_APP: begin
        wid_we = 1'b1;
        size_d[ph] = nsz;
        seen_we = 1'b1;
        seen_wdata = cur_q + 1'b1;
        match_d = (nsz == total_q);
        start_d = 16'(cpos_q + 1'b1 - PosW'(span));
        state_d = ((nsz == total_q) || fin_q) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (fin_q) begin
            pos_d = '0;
            vld_clr_all = 1'b1;
            for (int k = 0; k < WordMax; k++) begin
              head_d[k] = '0;
              size_d[k] = '0;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wl_q <= 4'd1;
      used_q <= '0;
      total_q <= '0;
      ovf_q <= 1'b0;
      fill_q <= '0;
      pos_q <= '0;
      text_q <= 1'b0;
      fin_q <= 1'b0;
      match_q <= 1'b0;
      dcnt_q <= '0;
      rem_q <= '0;
      idx_q <= '0;
      vld_q <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < WordMax; k++) begin
        head_q[k] <= '0;
        size_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite) wl_q <= pwdata[3:0];
      used_q <= used_d;
      total_q <= total_d;
      ovf_q <= ovf_d;
      fill_q <= fill_d;
      pos_q <= pos_d;
      text_q <= text_d;
      fin_q <= fin_d;
      match_q <= match_d;
      dcnt_q <= dcnt_d;
      rem_q <= rem_d;
      idx_q <= idx_d;
      head_q <= head_d;
      size_q <= size_d;
      if (vld_clr_all) begin
        vld_q <= '0;
      end else begin
        if (vld_clr_ph) vld_q[ph*DictMax +: DictMax] <= '0;
        if (seen_we) vld_q[seen_waddr] <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cpos_q <= cpos_d;
    div_q <= div_d;
    id_q <= id_d;
    old_q <= old_d;
    cur_q <= cur_d;
    start_q <= start_d;
    if (shift_en) begin
      recent_q[0] <= symbol_i;
      for (int k = 1; k < WordMax; k++) recent_q[k] <= recent_q[k-1];
    end
    if (dict_wr) begin
      words_q[idx_q[IdW-1:0]] <= word;
      counts_q[idx_q[IdW-1:0]] <= CntW'(1);
    end
    if (cnt_inc) counts_q[idx_q[IdW-1:0]] <= counts_q[idx_q[IdW-1:0]] + 1'b1;
    if (out_load) begin
      out_start_q <= match_q ? start_q : 16'd0;
      out_match_q <= match_q;
      out_end_q <= fin_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
    seen_rd_q <= seen_mem[seen_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wid_we) wid_mem[wid_waddr] <= id_q;
    wid_rd_q <= wid_mem[wid_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign match_start_o = out_start_q;
  assign is_match_o = out_match_q;
  assign is_end_o = out_end_q;
  assign dict_overflow_o = out_ovf_q;
  assign prdata = {28'd0, wl_q};
  assign pready = 1'b1;

endmodule

// ----- design/wbwm_checker.sv -----
module wbwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] match_start_o,
  input logic        is_match_o,
  input logic        is_end_o,
  input logic        pready
);

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(match_start_o))
    else $error("stalled result changed");

  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_match_o || is_end_o)
    else $error("result without match or end");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_match_o |-> match_start_o == 16'd0)
    else $error("start set without match");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind word_bag_window_matcher wbwm_checker u_wbwm_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .match_start_o(match_start_o),
  .is_match_o(is_match_o),
  .is_end_o(is_end_o),
  .pready(pready)
);
